/* design/psrgb_pkg.sv */
// Shared types, constants and pseudo-float helpers for the RGBA to sRGB16 encoder.
`timescale 1ns / 1ps
package psrgb_pkg;

  localparam int MANT_W       = 32;
  localparam int EXP_W        = 12;
  localparam int SEARCH_BITS  = 32;
  localparam int QUOT_BITS    = 12;
  localparam int FRONT_STAGES = 2;
  localparam int DIV_STAGES   = QUOT_BITS;
  localparam int POW5_STEPS   = 4;
  localparam int STEP_STAGES  = 14;
  localparam int BACK_STAGES  = 4;
  localparam int LANE_LAT     = FRONT_STAGES + DIV_STAGES + SEARCH_BITS * STEP_STAGES
                                + BACK_STAGES;

  // Linear segment test: c * 10^7 <= 31308 * a
  localparam logic [23:0] LIN_TH_C   = 24'd10000000;
  localparam logic [14:0] LIN_TH_A   = 15'd31308;
  // Linear code: (c * 1292 * 65535 * 2 + a * 100) / (a * 200)
  localparam logic [27:0] LIN_NUM_K  = 28'd169342440;
  localparam logic [6:0]  LIN_RND_K  = 7'd100;
  localparam logic [7:0]  LIN_DEN_K  = 8'd200;
  // Power segment code from the 32-bit fraction Y
  localparam logic [10:0] GAIN_K     = 11'd1055;
  localparam logic [42:0] OFFS_K     = 43'd55 << 32;
  localparam logic [9:0]  HALF_K     = 10'd1000;
  localparam logic [28:0] RECIP_2000 = 29'd274877907;
  localparam int          RECIP_SH   = 39;
  localparam logic [15:0] CODE_MAX   = 16'hFFFF;

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_LIN  = 2'd2;
  localparam logic [1:0] KIND_POW  = 2'd3;

  typedef struct packed {
    logic signed [23:0] red_in;
    logic signed [23:0] green_in;
    logic signed [23:0] blue_in;
    logic signed [23:0] alpha_in;
  } in_t;

  typedef struct packed {
    logic [15:0] red_code;
    logic [15:0] green_code;
    logic [15:0] blue_code;
    logic [15:0] alpha_code;
  } out_t;

  typedef struct packed {
    logic [MANT_W-1:0]       m;
    logic signed [EXP_W-1:0] e;
  } pf_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [QUOT_BITS-1:0]   lin_q;
    pf_t                    a5;
    pf_t                    c5;
    logic [SEARCH_BITS-1:0] y;
    logic [4:0]             lead;
    pf_t                    x;
    pf_t                    r;
  } srch_t;

  // Truncating product of two normalized mantissas.
  function automatic pf_t pf_mul(input pf_t a, input pf_t b);
    logic [2*MANT_W-1:0] p;
    pf_t res;
    p = (2*MANT_W)'(a.m) * (2*MANT_W)'(b.m);
    if (p[2*MANT_W-1]) begin
      res.m = p[2*MANT_W-1:MANT_W];
      res.e = a.e + b.e + EXP_W'(32);
    end else begin
      res.m = p[2*MANT_W-2:MANT_W-1];
      res.e = a.e + b.e + EXP_W'(31);
    end
    return res;
  endfunction

  function automatic logic pf_leq(input pf_t a, input pf_t b);
    if (a.e != b.e) begin
      return a.e < b.e;
    end
    return a.m <= b.m;
  endfunction

endpackage

/* design/psrgb_step.sv */
// One step of the bitwise root search: Y^12 * a^5 <= c^5 for one trial bit.
`timescale 1ns / 1ps
module psrgb_step #(
  parameter int BIT_POS = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  psrgb_pkg::srch_t  in_st,
  output logic              out_valid,
  output psrgb_pkg::srch_t  out_st
);

  localparam int NS = psrgb_pkg::STEP_STAGES;

  logic [NS-1:0]    v_r;
  psrgb_pkg::srch_t st_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // Stage 0: form the trial value and normalize it with the known leading bit.
  psrgb_pkg::srch_t s0_nxt;
  logic [31:0]      cand;
  logic [4:0]       msb;
  always_comb begin
    s0_nxt = in_st;
    cand   = in_st.y | (32'(1) << BIT_POS);
    msb    = (in_st.y == '0) ? 5'(BIT_POS) : in_st.lead;
    s0_nxt.x.m = cand << (5'd31 - msb);
    s0_nxt.x.e = $signed({7'b0, msb}) - 12'sd63;
    s0_nxt.r   = s0_nxt.x;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= s0_nxt;
  end

  // Stages 1..11 raise to the twelfth power, stage 12 scales by a^5.
  genvar j;
  generate
    for (j = 1; j < NS - 1; j++) begin : g_mul
      psrgb_pkg::srch_t m_nxt;
      always_comb begin
        m_nxt = st_r[j-1];
        if (j < NS - 2) begin
          m_nxt.r = psrgb_pkg::pf_mul(st_r[j-1].r, st_r[j-1].x);
        end else begin
          m_nxt.r = psrgb_pkg::pf_mul(st_r[j-1].r, st_r[j-1].a5);
        end
      end
      always_ff @(posedge clk) begin
        st_r[j] <= m_nxt;
      end
    end
  endgenerate

  // Last stage: keep the trial bit when the scaled power stays at or below c^5.
  psrgb_pkg::srch_t cmp_nxt;
  always_comb begin
    cmp_nxt = st_r[NS-2];
    if (psrgb_pkg::pf_leq(st_r[NS-2].r, st_r[NS-2].c5)) begin
      cmp_nxt.y = st_r[NS-2].y | (32'(1) << BIT_POS);
      if (st_r[NS-2].y == '0) begin
        cmp_nxt.lead = 5'(BIT_POS);
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r[NS-1] <= cmp_nxt;
  end

  assign out_valid = v_r[NS-1];
  assign out_st    = st_r[NS-1];

endmodule

/* design/psrgb_lane.sv */
// One colour lane: classify, linear-segment divider, power search and code rounding.
`timescale 1ns / 1ps
module psrgb_lane #(
  parameter int IN_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [23:0]      c_in,
  input  logic [IN_FRAC_BITS:0]   a_in,
  output logic                    out_valid,
  output logic [15:0]             code_out
);

  localparam int W  = IN_FRAC_BITS + 1;
  localparam int NW = W + 29;
  localparam int DW = W + 8;
  localparam int QB = psrgb_pkg::QUOT_BITS;
  localparam int SB = psrgb_pkg::SEARCH_BITS;

  typedef struct packed {
    logic [1:0]   kind;
    logic [W-1:0] c;
    logic [W-1:0] a;
  } cls_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [NW-1:0]    rem;
    logic [DW-1:0]    den;
    logic [QB-1:0]    q;
    psrgb_pkg::pf_t   ax;
    psrgb_pkg::pf_t   cx;
    psrgb_pkg::pf_t   a5;
    psrgb_pkg::pf_t   c5;
  } div_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [QB-1:0] lin_q;
    logic          low;
    logic [41:0]   t;
  } bk1_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [QB-1:0] lin_q;
    logic          low;
    logic [27:0]   w;
  } bk2_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [QB-1:0] lin_q;
    logic          low;
    logic [57:0]   prod;
  } bk3_t;

  function automatic psrgb_pkg::pf_t pf_make(input logic [W-1:0] x);
    logic [4:0]     msb;
    psrgb_pkg::pf_t res;
    msb = '0;
    for (int i = 0; i < W; i++) begin
      if (x[i]) begin
        msb = 5'(i);
      end
    end
    res.m = 32'(x) << (5'd31 - msb);
    res.e = $signed({7'b0, msb}) - 12'sd31;
    return res;
  endfunction

  // Classification stage
  logic             cls_v_r;
  cls_t             cls_r;
  cls_t             cls_nxt;
  logic [W-1:0]     c_n;
  logic [W+23:0]    lin_lhs;
  logic [W+23:0]    lin_rhs;

  always_comb begin
    c_n     = c_in[W-1:0];
    lin_lhs = (W+24)'(c_n) * (W+24)'(psrgb_pkg::LIN_TH_C);
    lin_rhs = (W+24)'(a_in) * (W+24)'(psrgb_pkg::LIN_TH_A);
    cls_nxt.c = c_n;
    cls_nxt.a = a_in;
    if (a_in == '0 || c_in <= 24'sd0) begin
      cls_nxt.kind = psrgb_pkg::KIND_ZERO;
    end else if ($signed(c_in) >= $signed(25'(a_in))) begin
      cls_nxt.kind = psrgb_pkg::KIND_FULL;
    end else if (lin_lhs <= lin_rhs) begin
      cls_nxt.kind = psrgb_pkg::KIND_LIN;
    end else begin
      cls_nxt.kind = psrgb_pkg::KIND_POW;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  // Setup stage: divider operands and normalized a, c
  logic dv0_v_r;
  div_t dv0_r;
  div_t dv0_nxt;

  always_comb begin
    dv0_nxt.kind = cls_r.kind;
    dv0_nxt.rem  = NW'(cls_r.c) * NW'(psrgb_pkg::LIN_NUM_K)
                 + NW'(cls_r.a) * NW'(psrgb_pkg::LIN_RND_K);
    dv0_nxt.den  = DW'(cls_r.a) * DW'(psrgb_pkg::LIN_DEN_K);
    dv0_nxt.q    = '0;
    dv0_nxt.ax   = pf_make(cls_r.a);
    dv0_nxt.cx   = pf_make(cls_r.c);
    dv0_nxt.a5   = dv0_nxt.ax;
    dv0_nxt.c5   = dv0_nxt.cx;
  end

  always_ff @(posedge clk) begin
    dv0_r <= dv0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_v_r <= 1'b0;
      dv0_v_r <= 1'b0;
    end else begin
      cls_v_r <= in_valid;
      dv0_v_r <= cls_v_r;
    end
  end

  // Restoring divider, one quotient bit per stage; a^5 and c^5 in the first stages
  logic [QB:0] dv_v;
  div_t        dv_st [QB+1];
  assign dv_v[0]  = dv0_v_r;
  assign dv_st[0] = dv0_r;

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_div
      div_t          d_nxt;
      div_t          d_r;
      logic          d_v_r;
      logic [NW-1:0] sub;
      always_comb begin
        d_nxt = dv_st[k];
        sub   = NW'(dv_st[k].den) << (QB - 1 - k);
        if (dv_st[k].rem >= sub) begin
          d_nxt.rem           = dv_st[k].rem - sub;
          d_nxt.q[QB - 1 - k] = 1'b1;
        end
        if (k < psrgb_pkg::POW5_STEPS) begin
          d_nxt.a5 = psrgb_pkg::pf_mul(dv_st[k].a5, dv_st[k].ax);
          d_nxt.c5 = psrgb_pkg::pf_mul(dv_st[k].c5, dv_st[k].cx);
        end
      end
      always_ff @(posedge clk) begin
        d_r <= d_nxt;
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          d_v_r <= 1'b0;
        end else begin
          d_v_r <= dv_v[k];
        end
      end
      assign dv_st[k+1] = d_r;
      assign dv_v[k+1]  = d_v_r;
    end
  endgenerate

  // Root search chain, most significant bit first
  logic [SB:0]      sv;
  psrgb_pkg::srch_t ss [SB+1];

  always_comb begin
    ss[0].kind  = dv_st[QB].kind;
    ss[0].lin_q = dv_st[QB].q;
    ss[0].a5    = dv_st[QB].a5;
    ss[0].c5    = dv_st[QB].c5;
    ss[0].y     = '0;
    ss[0].lead  = '0;
    ss[0].x     = '0;
    ss[0].r     = '0;
  end
  assign sv[0] = dv_v[QB];

  genvar g;
  generate
    for (g = 0; g < SB; g++) begin : g_step
      psrgb_step #(
        .BIT_POS (SB - 1 - g)
      ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sv[g]),
        .in_st     (ss[g]),
        .out_valid (sv[g+1]),
        .out_st    (ss[g+1])
      );
    end
  endgenerate

  // Code rounding: floor(65535 * (1.055 * y - 0.055) + 0.5)
  logic        b1_v_r, b2_v_r, b3_v_r, b4_v_r;
  bk1_t        b1_r, b1_nxt;
  bk2_t        b2_r, b2_nxt;
  bk3_t        b3_r, b3_nxt;
  logic [15:0] code_r, code_nxt;
  logic [42:0] yg;
  logic [58:0] num;
  logic [28:0] v;
  logic [18:0] qp;

  always_comb begin
    yg            = 43'(ss[SB].y) * 43'(psrgb_pkg::GAIN_K);
    b1_nxt.kind   = ss[SB].kind;
    b1_nxt.lin_q  = ss[SB].lin_q;
    b1_nxt.low    = yg <= psrgb_pkg::OFFS_K;
    b1_nxt.t      = 42'(yg - psrgb_pkg::OFFS_K);
  end

  always_comb begin
    num          = (59'(b1_r.t) << 16) - 59'(b1_r.t);
    b2_nxt.kind  = b1_r.kind;
    b2_nxt.lin_q = b1_r.lin_q;
    b2_nxt.low   = b1_r.low;
    b2_nxt.w     = num[58:31];
  end

  always_comb begin
    v            = 29'(b2_r.w) + 29'(psrgb_pkg::HALF_K);
    b3_nxt.kind  = b2_r.kind;
    b3_nxt.lin_q = b2_r.lin_q;
    b3_nxt.low   = b2_r.low;
    b3_nxt.prod  = 58'(v) * 58'(psrgb_pkg::RECIP_2000);
  end

  always_comb begin
    qp = b3_r.prod[57:psrgb_pkg::RECIP_SH];
    case (b3_r.kind)
      psrgb_pkg::KIND_ZERO: code_nxt = '0;
      psrgb_pkg::KIND_FULL: code_nxt = psrgb_pkg::CODE_MAX;
      psrgb_pkg::KIND_LIN:  code_nxt = 16'(b3_r.lin_q);
      psrgb_pkg::KIND_POW: begin
        if (b3_r.low) begin
          code_nxt = '0;
        end else if (qp > 19'(psrgb_pkg::CODE_MAX)) begin
          code_nxt = psrgb_pkg::CODE_MAX;
        end else begin
          code_nxt = qp[15:0];
        end
      end
      default: code_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    b1_r   <= b1_nxt;
    b2_r   <= b2_nxt;
    b3_r   <= b3_nxt;
    code_r <= code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
    end else begin
      b1_v_r <= sv[SB];
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
    end
  end

  assign out_valid = b4_v_r;
  assign code_out  = code_r;

endmodule

/* design/premultiplied_rgba_to_srgb16_top.sv */
// Top level: premultiplied RGBA pixel in, four 16-bit sRGB/alpha codes out.
`timescale 1ns / 1ps
// Usage:
//   Drive a premultiplied linear RGBA pixel on in_data (signed fixed point,
//   IN_FRAC_BITS fraction bits) and raise start. A request is taken at every
//   rising edge with start high and busy low; busy is always low, so one
//   pixel can be taken on every clock, back to back.
//   Each pixel's codes appear on out_data for exactly one cycle, flagged by
//   out_strobe, after passing the input, clamp, lane and merge registers.
//   Requests leave in the order they came in. Throughput is one pixel per clock.
//   Most of the depth is the root search in each colour lane: 32 trial bits,
//   each taking 14 stages (twelfth power by repeated 32x32 multiply, scale by
//   a^5, compare), plus the 12-stage linear-segment divider and the input,
//   clamp, classify, setup, rounding and merge stages.
//   Three identical colour lanes run side by side; alpha takes a short path
//   and a delay line, and a merge register joins the four codes.
//   Synchronous active-low reset clears all valid flags, so nothing comes out
//   until new requests arrive. The receiver cannot stall: results must be
//   taken in the cycle they are shown.
module premultiplied_rgba_to_srgb16_top #(
  parameter int IN_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  psrgb_pkg::in_t   in_data,
  output logic             out_strobe,
  output psrgb_pkg::out_t  out_data
);

  localparam int W   = IN_FRAC_BITS + 1;
  localparam int LAT = psrgb_pkg::LANE_LAT;
  localparam int ONE = 1 << IN_FRAC_BITS;

  // Never hold off a request: the pipeline takes one pixel per clock.
  assign busy = 1'b0;

  // Input register
  logic           in_v_r;
  psrgb_pkg::in_t in_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  // Clamp alpha to [0, 1]
  logic               cl_v_r;
  logic [W-1:0]       a_r, a_nxt;
  logic signed [23:0] cr_r, cg_r, cb_r;

  always_comb begin
    if (in_r.alpha_in < 24'sd0) begin
      a_nxt = '0;
    end else if (in_r.alpha_in > ONE) begin
      a_nxt = W'(ONE);
    end else begin
      a_nxt = in_r.alpha_in[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    cr_r <= in_r.red_in;
    cg_r <= in_r.green_in;
    cb_r <= in_r.blue_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      cl_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
      cl_v_r <= in_v_r;
    end
  end

  // Colour lanes
  logic        r_v, g_v, b_v;
  logic [15:0] r_code, g_code, b_code;

  psrgb_lane #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_lane_r (
    .clk(clk), .rst_n(rst_n), .in_valid(cl_v_r), .c_in(cr_r), .a_in(a_r),
    .out_valid(r_v), .code_out(r_code)
  );

  psrgb_lane #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_lane_g (
    .clk(clk), .rst_n(rst_n), .in_valid(cl_v_r), .c_in(cg_r), .a_in(a_r),
    .out_valid(g_v), .code_out(g_code)
  );

  psrgb_lane #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_lane_b (
    .clk(clk), .rst_n(rst_n), .in_valid(cl_v_r), .c_in(cb_r), .a_in(a_r),
    .out_valid(b_v), .code_out(b_code)
  );

  // Alpha code: round(a * 65535 / 2^F), then delay to line up with the lanes
  logic [W+15:0] a_scaled;
  logic [15:0]   a_code_line [LAT];

  assign a_scaled = (W+16)'(a_r) * (W+16)'(psrgb_pkg::CODE_MAX)
                  + ((W+16)'(1) << (IN_FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    a_code_line[0] <= a_scaled[IN_FRAC_BITS +: 16];
  end

  genvar d;
  generate
    for (d = 1; d < LAT; d++) begin : g_adly
      always_ff @(posedge clk) begin
        a_code_line[d] <= a_code_line[d-1];
      end
    end
  endgenerate

  // Merge the lane codes and alpha into one result
  logic            out_v_r;
  psrgb_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    out_r.red_code   <= r_code;
    out_r.green_code <= g_code;
    out_r.blue_code  <= b_code;
    out_r.alpha_code <= a_code_line[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= r_v && g_v && b_v;
    end
  end

  assign out_strobe = out_v_r;
  assign out_data   = out_r;

endmodule
